@@ rtl/u8seg_pkg.sv @@
// ----------------------------------------------------------------------------
// u8seg_pkg
// shared types, codes and the byte classifier for the utf-8 segmenter
// ----------------------------------------------------------------------------
package u8seg_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int START_BITS          = 16;
    localparam int MAX_RESULTS         = 3;

    localparam logic [2:0] MAX_SEG = 3'd7;

    // byte classes: continuation, ascii, lead 2..6, illegal
    localparam logic [2:0] CLS_CONT    = 3'd0;
    localparam logic [2:0] CLS_ASCII   = 3'd1;
    localparam logic [2:0] CLS_ILLEGAL = 3'd7;

    // result status codes
    localparam logic [1:0] ST_WELL_FORMED = 2'd0;
    localparam logic [1:0] ST_SINGLE      = 2'd1;
    localparam logic [1:0] ST_END         = 2'd2;

    typedef struct packed {
        logic [START_BITS-1:0] start;
        logic [2:0]            length;
        logic [1:0]            status;
    } seg_result_t;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] c;
        if (!b[7]) begin
            c = CLS_ASCII;
        end else if (!b[6]) begin
            c = CLS_CONT;
        end else if (!b[5]) begin
            c = 3'd2;
        end else if (!b[4]) begin
            c = 3'd3;
        end else if (!b[3]) begin
            c = 3'd4;
        end else if (!b[2]) begin
            c = 3'd5;
        end else if (!b[1]) begin
            c = 3'd6;
        end else begin
            c = CLS_ILLEGAL;
        end
        return c;
    endfunction

    function automatic seg_result_t make_result(input logic [START_BITS-1:0] start,
                                                input logic [2:0] length,
                                                input logic [1:0] status);
        seg_result_t r;
        r.start  = start;
        r.length = length;
        r.status = status;
        return r;
    endfunction

endpackage

@@ rtl/utf8_char_segmenter_top.sv @@
// ----------------------------------------------------------------------------
// utf8_char_segmenter_top
// cuts a byte stream into utf-8 character segments, one byte per request
// ----------------------------------------------------------------------------
// output: the first result of a byte shows on m_* in the cycle after it is taken
// throughput: one byte per cycle while each byte gives at most one result and m_ready
//   is high; a byte giving k results (up to 3) holds the input until the
//   single-result output port has drained the result slots
// reset: synchronous active-low aresetn empties the result slots and clears
//   all segment state and the byte offset
module utf8_char_segmenter_top #(
    parameter int OFFSET_BITS = u8seg_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    // segment results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_segment_start,
    output logic [2:0]  m_segment_length,
    output logic [1:0]  m_status,
    output logic        m_last_of_run
);

    // segment state
    logic [2:0]             open_length_reg,     open_length_next;
    logic [2:0]             declared_length_reg, declared_length_next;
    logic                   segment_open_reg,    segment_open_next;
    logic [OFFSET_BITS-1:0] open_start_reg,      open_start_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg,     byte_offset_next;
    logic                   text_ended_reg,      text_ended_next;

    // result slots, slot 0 is the head shown on m_*
    u8seg_pkg::seg_result_t slot_reg [u8seg_pkg::MAX_RESULTS];
    u8seg_pkg::seg_result_t slot_next[u8seg_pkg::MAX_RESULTS];
    logic [1:0]             count_reg, count_next;

    logic s_accept;
    logic m_pop;

    // offsets are reported as their low 16 bits, zero-extended when narrower
    function automatic logic [15:0] to_start(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    // accept when the slots are empty, or the last one leaves this cycle
    assign m_valid  = (count_reg != 2'd0);
    assign m_pop    = m_valid && m_ready;
    assign s_ready  = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign s_accept = s_valid && s_ready;

    assign m_segment_start  = slot_reg[0].start;
    assign m_segment_length = slot_reg[0].length;
    assign m_status         = slot_reg[0].status;
    assign m_last_of_run    = (count_reg == 2'd1);

    // one pass over the incoming byte: up to three results and the new state
    always_comb begin
        logic [2:0]             cls;
        logic [2:0]             len;
        logic [2:0]             decl;
        logic                   open;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] ofs_inc;
        logic [1:0]             n;

        cls     = u8seg_pkg::classify(s_data_byte);
        len     = open_length_reg;
        decl    = declared_length_reg;
        open    = segment_open_reg;
        start   = open_start_reg;
        ofs_inc = byte_offset_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        n       = 2'd0;
        for (int i = 0; i < u8seg_pkg::MAX_RESULTS; i++) begin
            slot_next[i] = u8seg_pkg::make_result(16'd0, 3'd0, u8seg_pkg::ST_END);
        end

        text_ended_next = text_ended_reg;

        if (text_ended_reg) begin
            // bytes after a zero byte are dropped
        end else if (s_data_byte == 8'd0) begin
            if (open) begin
                slot_next[n] = u8seg_pkg::make_result(to_start(start), len,
                    (len == decl) ? u8seg_pkg::ST_WELL_FORMED : u8seg_pkg::ST_SINGLE);
                n = n + 2'd1;
            end
            open = 1'b0;
            len  = 3'd0;
            decl = 3'd0;
            slot_next[n] = u8seg_pkg::make_result(to_start(byte_offset_reg), 3'd0,
                u8seg_pkg::ST_END);
            n = n + 2'd1;
            text_ended_next = 1'b1;
        end else begin
            if (open && (cls == u8seg_pkg::CLS_CONT)) begin
                len = len + 3'd1;
                // segment full at seven bytes
                if (len == u8seg_pkg::MAX_SEG) begin
                    slot_next[n] = u8seg_pkg::make_result(to_start(start), len,
                        (len == decl) ? u8seg_pkg::ST_WELL_FORMED : u8seg_pkg::ST_SINGLE);
                    n    = n + 2'd1;
                    open = 1'b0;
                    len  = 3'd0;
                    decl = 3'd0;
                end
            end else begin
                // foreign byte closes the open segment first
                if (open) begin
                    slot_next[n] = u8seg_pkg::make_result(to_start(start), len,
                        (len == decl) ? u8seg_pkg::ST_WELL_FORMED : u8seg_pkg::ST_SINGLE);
                    n = n + 2'd1;
                end
                open = 1'b0;
                len  = 3'd0;
                decl = 3'd0;
                if ((cls == u8seg_pkg::CLS_ASCII) || (cls == u8seg_pkg::CLS_ILLEGAL)) begin
                    slot_next[n] = u8seg_pkg::make_result(to_start(byte_offset_reg), 3'd1,
                        u8seg_pkg::ST_SINGLE);
                    n = n + 2'd1;
                end else begin
                    // lead byte, or a stray continuation with declared length 0
                    open  = 1'b1;
                    len   = 3'd1;
                    decl  = cls;
                    start = byte_offset_reg;
                end
            end
            if (s_final_byte) begin
                if (open) begin
                    slot_next[n] = u8seg_pkg::make_result(to_start(start), len,
                        (len == decl) ? u8seg_pkg::ST_WELL_FORMED : u8seg_pkg::ST_SINGLE);
                    n = n + 2'd1;
                end
                open = 1'b0;
                len  = 3'd0;
                decl = 3'd0;
                slot_next[n] = u8seg_pkg::make_result(to_start(ofs_inc), 3'd0,
                    u8seg_pkg::ST_END);
                n = n + 2'd1;
            end
        end

        // end of buffer clears everything for the next one
        if (s_final_byte) begin
            byte_offset_next = '0;
            text_ended_next  = 1'b0;
            open             = 1'b0;
            len              = 3'd0;
            decl             = 3'd0;
        end else begin
            byte_offset_next = ofs_inc;
        end

        open_length_next     = len;
        declared_length_next = decl;
        segment_open_next    = open;
        open_start_next      = start;
        count_next           = n;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg           <= 2'd0;
            open_length_reg     <= 3'd0;
            declared_length_reg <= 3'd0;
            segment_open_reg    <= 1'b0;
            open_start_reg      <= '0;
            byte_offset_reg     <= '0;
            text_ended_reg      <= 1'b0;
        end else if (s_accept) begin
            count_reg           <= count_next;
            open_length_reg     <= open_length_next;
            declared_length_reg <= declared_length_next;
            segment_open_reg    <= segment_open_next;
            open_start_reg      <= open_start_next;
            byte_offset_reg     <= byte_offset_next;
            text_ended_reg      <= text_ended_next;
        end else if (m_pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // result payload, shifts toward the head as results leave
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < u8seg_pkg::MAX_RESULTS; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end else if (m_pop) begin
            for (int i = 0; i < u8seg_pkg::MAX_RESULTS - 1; i++) begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

endmodule

@@ rtl/u8seg_checker.sv @@
// ----------------------------------------------------------------------------
// u8seg_checker
// port-level checks on the segmenter result stream
// ----------------------------------------------------------------------------
module u8seg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_segment_start,
    input logic [2:0]  m_segment_length,
    input logic [1:0]  m_status,
    input logic        m_last_of_run
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_segment_start)
            && $stable(m_segment_length) && $stable(m_status) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    // end of text carries no length
    a_end_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == u8seg_pkg::ST_END) |-> m_segment_length == 3'd0)
        else $error("end of text with nonzero length");

    // well-formed segments are multibyte and shorter than seven bytes
    a_wf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == u8seg_pkg::ST_WELL_FORMED)
            |-> (m_segment_length >= 3'd2) && (m_segment_length != 3'd7))
        else $error("well-formed segment with bad length");

    // only end of text may be empty
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_segment_length == 3'd0) |-> m_status == u8seg_pkg::ST_END)
        else $error("empty segment that is not end of text");

    // idle output never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

endmodule

bind utf8_char_segmenter_top u8seg_checker u_u8seg_checker (.*);
